FILE: rtl/windowed_rms_meter_unit_defines.svh
// Assertion macros for the windowed RMS meter checker.
// Depends on a clk and rst_n signal in the scope of use.
`ifndef WINDOWED_RMS_METER_UNIT_DEFINES_SVH
`define WINDOWED_RMS_METER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define WRMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wrms check failed");

// Next-cycle implication, disabled in reset
`define WRMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wrms check failed");

`endif

FILE: rtl/wrms_pkg.sv
// Shared types and constants of the windowed RMS meter.
// No dependencies.
package wrms_pkg;

    localparam int ACC_W     = 35;
    localparam int WIN_W     = 11;
    localparam int CH_W      = 3;
    localparam int SCALE_W   = 32;
    localparam int ROOT_W    = 18;
    localparam int RMS_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int DIV_STEPS  = ACC_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_LAST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LAST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_SCALE = 3'd5;

    localparam logic [WIN_W-1:0]   RST_WINDOW_LEN    = 11'd300;
    localparam logic [CH_W-1:0]    RST_VOLTAGE_LAST  = 3'd2;
    localparam logic [CH_W-1:0]    RST_CURRENT_FIRST = 3'd3;
    localparam logic [CH_W-1:0]    RST_CURRENT_LAST  = 3'd5;
    localparam logic [SCALE_W-1:0] RST_VOLTAGE_SCALE = 32'd179040484;
    localparam logic [SCALE_W-1:0] RST_CURRENT_SCALE = 32'd1048832;

    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef struct packed {
        logic               start;
        logic [ACC_W-1:0]   sum;
        logic [WIN_W-1:0]   win;
        logic [SCALE_W-1:0] scale;
    } wrms_root_req_t;

    typedef struct packed {
        logic             done;
        logic [RMS_W-1:0] value;
    } wrms_root_rsp_t;

endpackage

FILE: rtl/wrms_if.sv
// Channel interfaces of the windowed RMS meter: sample input and result output.
// Depends on wrms_pkg.
interface wrms_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [wrms_pkg::CH_W-1:0]   channel;
    logic [SAMPLE_BITS-1:0]      sample;
    logic                        frame_end;

    modport source (output valid, req_type, channel, sample, frame_end, input ready);
    modport sink (input valid, req_type, channel, sample, frame_end, output ready);
endinterface

interface wrms_out_if;
    logic                        valid;
    logic                        ready;
    logic [wrms_pkg::CH_W-1:0]   out_channel;
    logic [wrms_pkg::RMS_W-1:0]  rms_value;
    logic                        last;

    modport source (output valid, out_channel, rms_value, last, input ready);
    modport sink (input valid, out_channel, rms_value, last, output ready);
endinterface

FILE: rtl/windowed_rms_meter_unit.sv
// Top level of the windowed RMS meter: accumulators, sequencer, config, output.
// Depends on wrms_pkg, wrms_if.sv and wrms_root_unit.
//
//  channel    | dir | transaction
//  -----------+-----+------------------------------------------------
//  sample_ch  | in  | req_type, channel, sample, frame_end
//  result_ch  | out | out_channel, rms_value, last
//  cfg_*      | in  | register write, index and data
//
// A sample passes the squarer and accumulate states, and a window check with frame_end set.
// A report runs each included channel, in channel order, through the shared
// divide/sqrt/multiply unit, scanning past the channels it leaves out.
// Reset clears accumulators, frame count and loads register defaults.
// A stalled result holds the report sequence.
module windowed_rms_meter_unit #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 12,
    parameter int WINDOW_MAX   = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    wrms_in_if.sink                          sample_ch,
    wrms_out_if.source                       result_ch,
    input  logic                             cfg_we,
    input  logic [wrms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wrms_pkg::CFG_DAT_W-1:0]   cfg_data
);

    localparam int ACC_W = wrms_pkg::ACC_W;
    localparam int CH_W  = wrms_pkg::CH_W;
    localparam int WIN_W = wrms_pkg::WIN_W;
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam logic [CH_W:0] NUM_CH_L = (CH_W + 1)'(NUM_CHANNELS);
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
    localparam logic [SAMPLE_BITS:0] FULL = (SAMPLE_BITS + 1)'((1 << SAMPLE_BITS) - 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SQUARE = 7'b0000010,
        S_ACC    = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_ROOT   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } seq_state_t;

    seq_state_t                 state_reg, state_next;
    logic [ACC_W-1:0]           sums_reg [NUM_CHANNELS];
    logic [WIN_W-1:0]           count_reg;
    logic [CH_W-1:0]            ch_reg;
    logic                       fend_reg;
    logic [SAMPLE_BITS-1:0]     d_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [CH_W-1:0]            scan_reg;
    logic [wrms_pkg::RMS_W-1:0] value_reg;

    logic [WIN_W-1:0]           window_len_reg;
    logic [CH_W-1:0]            voltage_last_reg;
    logic [CH_W-1:0]            current_first_reg;
    logic [CH_W-1:0]            current_last_reg;
    logic [wrms_pkg::SCALE_W-1:0] voltage_scale_reg;
    logic [wrms_pkg::SCALE_W-1:0] current_scale_reg;

    logic                       out_valid_reg;
    logic [CH_W-1:0]            out_channel_reg;
    logic [wrms_pkg::RMS_W-1:0] out_value_reg;
    logic                       out_last_reg;

    wrms_pkg::wrms_root_req_t   root_req;
    wrms_pkg::wrms_root_rsp_t   root_rsp;

    logic                       in_fire;
    logic [SAMPLE_BITS:0]       two_s;
    logic [SAMPLE_BITS:0]       d_wide;
    logic [WIN_W-1:0]           win;
    logic [NUM_CHANNELS-1:0]    incl;
    logic                       scan_is_volt;
    logic                       scan_is_last;
    logic [ACC_W:0]             acc_sum;
    logic                       emit_ok;
    logic                       clear_all;

    assign in_fire         = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready = (state_reg == S_IDLE);
    assign emit_ok         = !out_valid_reg || result_ch.ready;

    // centre the reading: |2*s - full|
    always_comb
    begin
        two_s = {sample_ch.sample, 1'b0};
        if (two_s >= FULL)
        begin
            d_wide = two_s - FULL;
        end
        else
        begin
            d_wide = FULL - two_s;
        end
    end

    always_comb
    begin
        if (window_len_reg == '0)
        begin
            win = WIN_W'(1);
        end
        else if ({2'b00, window_len_reg} > (WIN_W + 2)'(WINDOW_MAX))
        begin
            win = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win = window_len_reg;
        end
    end

    // which channels a report holds, and whether scan_reg is the final one
    always_comb
    begin
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            incl[c] = (CH_W'(c) <= voltage_last_reg) ||
                      ((CH_W'(c) >= current_first_reg) && (CH_W'(c) <= current_last_reg));
        end
        scan_is_volt = (scan_reg <= voltage_last_reg);
        scan_is_last = 1'b1;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if ((CH_W'(c) > scan_reg) && incl[c])
            begin
                scan_is_last = 1'b0;
            end
        end
    end

    assign acc_sum = {1'b0, sums_reg[ch_reg[IDX_W-1:0]]} + (ACC_W + 1)'(sq_reg);

    always_comb
    begin
        state_next     = state_reg;
        clear_all      = 1'b0;
        root_req.start = 1'b0;
        root_req.sum   = sums_reg[scan_reg[IDX_W-1:0]];
        root_req.win   = win;
        root_req.scale = scan_is_volt ? voltage_scale_reg : current_scale_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (sample_ch.req_type == wrms_pkg::REQ_RESTART)
                    begin
                        clear_all = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SQUARE;
                    end
                end
            end
            S_SQUARE:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = fend_reg ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                state_next = (count_reg >= win) ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                if (incl[scan_reg[IDX_W-1:0]])
                begin
                    root_req.start = 1'b1;
                    state_next     = S_ROOT;
                end
                else if (scan_reg == LAST_CH)
                begin
                    clear_all  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                if (root_rsp.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    if (scan_is_last || scan_reg == LAST_CH)
                    begin
                        clear_all  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                sums_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clear_all)
            begin
                count_reg <= '0;
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    sums_reg[c] <= '0;
                end
            end
            else if (state_reg == S_ACC)
            begin
                if ({1'b0, ch_reg} < NUM_CH_L)
                begin
                    // saturate the accumulator
                    sums_reg[ch_reg[IDX_W-1:0]] <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                end
                if (fend_reg)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (state_reg == S_CHECK)
        begin
            scan_reg <= '0;
        end
        else if ((state_reg == S_SCAN && !incl[scan_reg[IDX_W-1:0]] && scan_reg != LAST_CH) ||
                 (state_reg == S_EMIT && emit_ok))
        begin
            scan_reg <= scan_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg   <= sample_ch.channel;
            fend_reg <= sample_ch.frame_end;
            d_reg    <= d_wide[SAMPLE_BITS-1:0];
        end
        sq_reg <= d_reg * d_reg;
        if (state_reg == S_ROOT && root_rsp.done)
        begin
            value_reg <= root_rsp.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg    <= wrms_pkg::RST_WINDOW_LEN;
            voltage_last_reg  <= wrms_pkg::RST_VOLTAGE_LAST;
            current_first_reg <= wrms_pkg::RST_CURRENT_FIRST;
            current_last_reg  <= wrms_pkg::RST_CURRENT_LAST;
            voltage_scale_reg <= wrms_pkg::RST_VOLTAGE_SCALE;
            current_scale_reg <= wrms_pkg::RST_CURRENT_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wrms_pkg::CFG_WINDOW_LEN:    window_len_reg    <= cfg_data[WIN_W-1:0];
                wrms_pkg::CFG_VOLTAGE_LAST:  voltage_last_reg  <= cfg_data[CH_W-1:0];
                wrms_pkg::CFG_CURRENT_FIRST: current_first_reg <= cfg_data[CH_W-1:0];
                wrms_pkg::CFG_CURRENT_LAST:  current_last_reg  <= cfg_data[CH_W-1:0];
                wrms_pkg::CFG_VOLTAGE_SCALE: voltage_scale_reg <= cfg_data;
                wrms_pkg::CFG_CURRENT_SCALE: current_scale_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_EMIT && emit_ok)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && emit_ok)
        begin
            out_channel_reg <= scan_reg;
            out_value_reg   <= value_reg;
            out_last_reg    <= scan_is_last;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.out_channel = out_channel_reg;
    assign result_ch.rms_value   = out_value_reg;
    assign result_ch.last        = out_last_reg;

    wrms_root_unit u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .rsp   (root_rsp)
    );

endmodule

FILE: rtl/wrms_root_unit.sv
// Iterative sum/window divide, bit-serial square root and scale multiply.
// Depends on wrms_pkg.
module wrms_root_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wrms_pkg::wrms_root_req_t req,
    output wrms_pkg::wrms_root_rsp_t rsp
);

    typedef enum logic [4:0] {
        R_IDLE = 5'b00001,
        R_DIV  = 5'b00010,
        R_SQRT = 5'b00100,
        R_MUL  = 5'b01000,
        R_SAT  = 5'b10000
    } root_state_t;

    localparam int ACC_W = wrms_pkg::ACC_W;
    localparam int WIN_W = wrms_pkg::WIN_W;

    root_state_t                      state_reg, state_next;
    logic [wrms_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [ACC_W-1:0]                 val_reg, val_next;
    logic [WIN_W-1:0]                 rem_reg, rem_next;
    logic [WIN_W-1:0]                 div_reg, div_next;
    logic [ACC_W:0]                   res_reg, res_next;
    logic [ACC_W-1:0]                 bit_reg, bit_next;
    logic [wrms_pkg::SCALE_W-1:0]     scale_reg, scale_next;
    logic [wrms_pkg::ROOT_W+wrms_pkg::SCALE_W-1:0] prod_reg, prod_next;
    logic [wrms_pkg::RMS_W-1:0]       out_reg, out_next;
    logic                             done_reg, done_next;

    logic [WIN_W:0]   shifted;
    logic [ACC_W:0]   trial;
    logic [wrms_pkg::ROOT_W+wrms_pkg::SCALE_W-17:0] q;

    always_comb
    begin
        shifted    = {rem_reg, val_reg[ACC_W-1]};
        trial      = res_reg + {1'b0, bit_reg};
        q          = prod_reg[wrms_pkg::ROOT_W+wrms_pkg::SCALE_W-1:16];
        state_next = state_reg;
        step_next  = step_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        scale_next = scale_reg;
        prod_next  = prod_reg;
        out_next   = out_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            R_IDLE:
            begin
                if (req.start)
                begin
                    val_next   = req.sum;
                    div_next   = req.win;
                    scale_next = req.scale;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = R_DIV;
                end
            end
            R_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (shifted >= {1'b0, div_reg})
                begin
                    rem_next = WIN_W'(shifted - {1'b0, div_reg});
                    val_next = {val_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[WIN_W-1:0];
                    val_next = {val_reg[ACC_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == wrms_pkg::STEP_W'(wrms_pkg::DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    res_next   = '0;
                    bit_next   = ACC_W'(1) << (2 * (wrms_pkg::SQRT_STEPS - 1));
                    state_next = R_SQRT;
                end
            end
            R_SQRT:
            begin
                if ({1'b0, val_reg} >= trial)
                begin
                    val_next = val_reg - trial[ACC_W-1:0];
                    res_next = (res_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 1'b1;
                if (step_reg == wrms_pkg::STEP_W'(wrms_pkg::SQRT_STEPS - 1))
                begin
                    state_next = R_MUL;
                end
            end
            R_MUL:
            begin
                prod_next  = res_reg[wrms_pkg::ROOT_W-1:0] * scale_reg;
                state_next = R_SAT;
            end
            R_SAT:
            begin
                // saturate at all ones
                if (q[$bits(q)-1:wrms_pkg::RMS_W] != '0)
                begin
                    out_next = '1;
                end
                else
                begin
                    out_next = q[wrms_pkg::RMS_W-1:0];
                end
                done_next  = 1'b1;
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        scale_reg <= scale_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = out_reg;

endmodule

FILE: rtl/wrms_checker.sv
// Port-level checks of the windowed RMS meter, bound to the top level.
// Depends on windowed_rms_meter_unit_defines.svh.
`include "windowed_rms_meter_unit_defines.svh"

module wrms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        req_type,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] rms_value
);

    `WRMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `WRMS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(rms_value))
    `WRMS_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && !req_type, !in_ready)
    `WRMS_ASSERT_NEXT(a_restart_quick, in_valid && in_ready && req_type, in_ready)
    `WRMS_ASSERT_NOW(a_result_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind windowed_rms_meter_unit wrms_checker u_wrms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .req_type  (sample_ch.req_type),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .rms_value (result_ch.rms_value)
);
